/* hdl/ddo_pkg.sv */
// shared types and constants of the differential drive odometry block
// no dependencies
package ddo_pkg;

  // angle units are 1/64 degree
  localparam int unsigned FullTurn    = 23040;
  localparam int unsigned HalfTurn    = 11520;
  localparam int unsigned QuarterTurn = 5760;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned CordicGain  = 652032874;

  // a full turn is 45 * 2^9; the heading reduction divides the part above the
  // low nine bits by 45 with a reciprocal, ceil(2^28 / 45), exact up to 2^22
  localparam int unsigned TurnOdd        = 45;
  localparam int unsigned TurnShift      = 9;
  localparam int unsigned TurnRecip      = 5965233;
  localparam int unsigned TurnRecipShift = 28;

  // folded angle in [-90, 90] degrees plus the half-turn flag
  typedef struct packed {
    logic signed [13:0] angle;
    logic               neg;
  } fold_t;

  // sine and cosine in q1.15
  typedef struct packed {
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } trig_t;

  // arctangent of 2^-i in 2^-22 degree
  function automatic logic [28:0] arc_atan(input logic [3:0] idx);
    logic [28:0] v;
    case (idx)
      4'd0:    v = 29'd188743680;
      4'd1:    v = 29'd111421900;
      4'd2:    v = 29'd58872272;
      4'd3:    v = 29'd29884485;
      4'd4:    v = 29'd15000234;
      4'd5:    v = 29'd7507429;
      4'd6:    v = 29'd3754630;
      4'd7:    v = 29'd1877430;
      4'd8:    v = 29'd938730;
      4'd9:    v = 29'd469366;
      4'd10:   v = 29'd234683;
      4'd11:   v = 29'd117342;
      4'd12:   v = 29'd58671;
      4'd13:   v = 29'd29335;
      4'd14:   v = 29'd14668;
      default: v = 29'd7334;
    endcase
    return v;
  endfunction

endpackage

/* hdl/ddo_if.sv */
// valid/ready channel interfaces of the odometry block
// no dependencies
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [14:0] yaw_reading;
  logic signed [31:0] left_distance;
  logic signed [31:0] right_distance;

  modport source (output valid, mode, yaw_reading, left_distance, right_distance,
                  input ready);
  modport sink   (input valid, mode, yaw_reading, left_distance, right_distance,
                  output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] relative_heading;

  modport source (output valid, pos_x, pos_y, relative_heading, input ready);
  modport sink   (input valid, pos_x, pos_y, relative_heading, output ready);
endinterface

/* hdl/differential_drive_odometry.sv */
// differential drive dead-reckoning odometry, top level with sequencer
// depends on ddo_pkg, ddo_if, ddo_hred, ddo_cordic
//
//   channel  dir  word contents                                       handshake
//   in_i     in   mode, yaw_reading, left_distance, right_distance    valid/ready
//   out_o    out  pos_x, pos_y, relative_heading                      valid/ready
//
// one word at a time: in_i.ready is high only while the sequencer is idle
// and no finished result is waiting for the output register
// an update word passes four setup steps (unwrap, travel, delta, mean), the
// heading reduction, the cordic and four multiply-accumulate steps, and then
// hands its result over; a start word passes the unwrap and origin steps
// the result sits in an output register, so a new word is taken while it waits
// a stalled output keeps the next finished result in the sequencer and
// in_i.ready low until the output register frees
// reset clears the heading, origins, travel and position to zero
module differential_drive_odometry import ddo_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ddo_in_if.sink       in_i,
  ddo_out_if.source    out_o
);

  // one-hot sequencer
  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_UNWRAP = 12'b000000000010,
    S_ORIGIN = 12'b000000000100,
    S_TRAVEL = 12'b000000001000,
    S_DELTA  = 12'b000000010000,
    S_MEAN   = 12'b000000100000,
    S_REDUCE = 12'b000001000000,
    S_CORDIC = 12'b000010000000,
    S_MULX   = 12'b000100000000,
    S_ACCX   = 12'b001000000000,
    S_MULY   = 12'b010000000000,
    S_ACCY   = 12'b100000000000
  } seq_state_e;

  seq_state_e state_q, state_d;

  // captured input word
  logic               mode_q;
  logic signed [14:0] yaw_q;
  logic signed [31:0] left_q, right_q;

  // odometry state
  logic signed [14:0] prev_yaw_q;
  logic signed [31:0] unwrap_q, start_q;
  logic signed [31:0] lorig_q, rorig_q;
  logic signed [31:0] plt_q, prt_q;
  logic signed [31:0] pos_x_q, pos_y_q;

  // per-word scratch
  logic signed [31:0] lt_q, rt_q, ls_q, rs_q;
  logic signed [31:0] step_q, rel_q;
  logic signed [47:0] prod_q;

  // output register
  logic               out_valid_q;
  logic signed [31:0] out_x_q, out_y_q, out_rel_q;
  logic               out_load;
  logic               done_q;

  // helper units
  logic  red_start, red_done;
  fold_t fold;
  logic  cor_start, cor_done;
  trig_t trig;

  ddo_hred u_hred (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .rel_i   (rel_q),
    .done_o  (red_done),
    .fold_o  (fold)
  );

  ddo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .fold_i  (fold),
    .done_o  (cor_done),
    .trig_o  (trig)
  );

  // yaw unwrap: a jump of more than half a turn is a pass through +-180
  logic signed [15:0] yaw_diff, yaw_step;
  always_comb begin
    yaw_diff = {yaw_q[14], yaw_q} - {prev_yaw_q[14], prev_yaw_q};
    if (yaw_diff < -16'sd11520) begin
      yaw_step = yaw_diff + 16'(FullTurn);
    end else if (yaw_diff > 16'sd11520) begin
      yaw_step = yaw_diff - 16'(FullTurn);
    end else begin
      yaw_step = yaw_diff;
    end
  end

  // mean wheel step, floor of the 33-bit half sum
  logic signed [32:0] step_sum;
  assign step_sum = {ls_q[31], ls_q} + {rs_q[31], rs_q};

  // shared multiplier, sine for x then cosine for y
  logic signed [15:0] mul_op;
  logic signed [47:0] prod_d;
  assign mul_op = (state_q == S_MULX) ? trig.sin_v : trig.cos_v;
  assign prod_d = step_q * mul_op;

  // shared rounding and saturating accumulate
  logic signed [47:0] prod_rnd;
  logic signed [32:0] incr;
  logic signed [31:0] acc_base, acc_sat;
  logic signed [33:0] acc_sum;
  always_comb begin
    prod_rnd = prod_q + 48'sd16384;
    incr     = prod_rnd[47:15];
    acc_base = (state_q == S_ACCX) ? pos_x_q : pos_y_q;
    acc_sum  = {{2{acc_base[31]}}, acc_base} + {incr[32], incr};
    if (acc_sum > 34'sd2147483647) begin
      acc_sat = 32'sh7fffffff;
    end else if (acc_sum < -34'sd2147483648) begin
      acc_sat = 32'sh80000000;
    end else begin
      acc_sat = acc_sum[31:0];
    end
  end

  // done_q marks a word whose result waits for the output register
  assign out_load = done_q && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    red_start = 1'b0;
    cor_start = 1'b0;
    unique case (state_q)
      S_IDLE:   if (in_i.valid && !done_q) state_d = S_UNWRAP;
      S_UNWRAP: state_d = mode_q ? S_TRAVEL : S_ORIGIN;
      S_ORIGIN: state_d = S_IDLE;
      S_TRAVEL: state_d = S_DELTA;
      S_DELTA:  state_d = S_MEAN;
      S_MEAN: begin
        red_start = 1'b1;
        state_d   = S_REDUCE;
      end
      S_REDUCE: begin
        if (red_done) begin
          cor_start = 1'b1;
          state_d   = S_CORDIC;
        end
      end
      S_CORDIC: if (cor_done) state_d = S_MULX;
      S_MULX:   state_d = S_ACCX;
      S_ACCX:   state_d = S_MULY;
      S_MULY:   state_d = S_ACCY;
      S_ACCY:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE) && !done_q;

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      prev_yaw_q  <= '0;
      unwrap_q    <= '0;
      start_q     <= '0;
      lorig_q     <= '0;
      rorig_q     <= '0;
      plt_q       <= '0;
      prt_q       <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
    end else begin
      state_q <= state_d;

      if (out_load) begin
        done_q <= 1'b0;
      end else if ((state_q == S_ORIGIN) || (state_q == S_ACCY)) begin
        done_q <= 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_UNWRAP: begin
          unwrap_q   <= unwrap_q + 32'(yaw_step);
          prev_yaw_q <= yaw_q;
        end
        S_ORIGIN: begin
          start_q <= unwrap_q;
          lorig_q <= left_q;
          rorig_q <= right_q;
          plt_q   <= '0;
          prt_q   <= '0;
          pos_x_q <= '0;
          pos_y_q <= '0;
        end
        S_DELTA: begin
          plt_q <= lt_q;
          prt_q <= rt_q;
        end
        S_ACCX:  pos_x_q <= acc_sat;
        S_ACCY:  pos_y_q <= acc_sat;
        default: ;
      endcase
    end
  end

  // datapath scratch, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q  <= in_i.mode;
      yaw_q   <= in_i.yaw_reading;
      left_q  <= in_i.left_distance;
      right_q <= in_i.right_distance;
    end
    unique case (state_q)
      S_ORIGIN: rel_q <= '0;
      S_TRAVEL: begin
        lt_q  <= left_q - lorig_q;
        rt_q  <= right_q - rorig_q;
        rel_q <= unwrap_q - start_q;
      end
      S_DELTA: begin
        ls_q <= lt_q - plt_q;
        rs_q <= rt_q - prt_q;
      end
      S_MEAN:  step_q <= step_sum[32:1];
      S_MULX,
      S_MULY:  prod_q <= prod_d;
      default: ;
    endcase
    if (out_load) begin
      out_x_q   <= pos_x_q;
      out_y_q   <= pos_y_q;
      out_rel_q <= rel_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.pos_x            = out_x_q;
  assign out_o.pos_y            = out_y_q;
  assign out_o.relative_heading = out_rel_q;

endmodule

/* hdl/ddo_hred.sv */
// heading reduction modulo a full turn by reciprocal multiplication, then fold to +-90 deg
// depends on ddo_pkg
module ddo_hred import ddo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] rel_i,
  output logic               done_o,
  output fold_t              fold_o
);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_RUN  = 3'b010,
    R_FOLD = 3'b100
  } red_state_e;

  red_state_e  state_q, state_d;
  logic [31:0] mag_q;
  logic [16:0] quo_q;
  logic        sign_q;
  logic        done_q;
  fold_t       fold_q, fold_d;

  // only the bits above the low nine see the divide by 45
  logic [22:0]        hi_part;
  logic [45:0]        quo_prod;
  logic [22:0]        quo_back;
  logic [22:0]        rem_hi;
  logic [14:0]        r_mod;
  logic signed [15:0] r_s;
  logic signed [15:0] a_s;

  assign hi_part  = mag_q[31:TurnShift];
  assign quo_prod = 46'(hi_part) * 46'(TurnRecip);
  assign quo_back = 23'(quo_q) * 23'(TurnOdd);
  assign rem_hi   = hi_part - quo_back;

  // final remainder, corrected for a negative heading, then folded
  always_comb begin
    r_mod = {rem_hi[5:0], mag_q[TurnShift-1:0]};
    if (sign_q && (r_mod != 15'd0)) begin
      r_mod = 15'(FullTurn) - r_mod;
    end
    r_s = signed'({1'b0, r_mod});
    fold_d.neg = 1'b0;
    if ((r_s > 16'sd5760) && (r_s <= 16'sd17280)) begin
      a_s = r_s - 16'(HalfTurn);
      fold_d.neg = 1'b1;
    end else if (r_s > 16'sd17280) begin
      a_s = r_s - 16'(FullTurn);
    end else begin
      a_s = r_s;
    end
    fold_d.angle = a_s[13:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      R_IDLE: if (start_i) state_d = R_RUN;
      R_RUN:  state_d = R_FOLD;
      R_FOLD: state_d = R_IDLE;
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == R_FOLD);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      R_IDLE: begin
        if (start_i) begin
          sign_q <= rel_i[31];
          mag_q  <= rel_i[31] ? (~rel_i + 32'd1) : rel_i;
        end
      end
      R_RUN:  quo_q  <= quo_prod[TurnRecipShift +: 17];
      R_FOLD: fold_q <= fold_d;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign fold_o = fold_q;

endmodule

/* hdl/ddo_cordic.sv */
// iterative rotation cordic, one micro-rotation per cycle, q1.15 sin and cos
// depends on ddo_pkg
module ddo_cordic import ddo_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  fold_t fold_i,
  output logic  done_o,
  output trig_t trig_o
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_OUT  = 3'b100
  } cor_state_e;

  cor_state_e         state_q, state_d;
  logic signed [33:0] x_q, y_q;
  logic signed [31:0] z_q;
  logic [3:0]         i_q;
  logic               neg_q;
  logic               done_q;
  trig_t              trig_q;

  logic signed [33:0] xs, ys, xf, yf;
  logic signed [31:0] atan_s;

  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [15:0] r;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (t < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  assign xs     = x_q >>> i_q;
  assign ys     = y_q >>> i_q;
  assign atan_s = signed'({3'b000, arc_atan(i_q)});
  assign xf     = neg_q ? -x_q : x_q;
  assign yf     = neg_q ? -y_q : y_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE: if (start_i) state_d = C_RUN;
      C_RUN:  if (i_q == 4'(CordicSteps - 1)) state_d = C_OUT;
      C_OUT:  state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == C_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          x_q   <= 34'(CordicGain);
          y_q   <= '0;
          // angle in 2^-22 degree
          z_q   <= {{2{fold_i.angle[13]}}, fold_i.angle, 16'h0000};
          i_q   <= '0;
          neg_q <= fold_i.neg;
        end
      end
      C_RUN: begin
        if (!z_q[31]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_s;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_s;
        end
        i_q <= i_q + 4'd1;
      end
      C_OUT: begin
        trig_q.sin_v <= to_q15(yf);
        trig_q.cos_v <= to_q15(xf);
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign trig_o = trig_q;

endmodule
